FILE: rtl/dltd_pkg.sv
// Shared types, constants and helper functions for the log message deframer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package dltd_pkg;

  localparam logic [31:0] SERIAL_WORD     = 32'h444C_5301;
  localparam logic [17:0] BUF_SIZE_RESET  = 18'd65536;
  localparam logic [4:0]  STD_HDR_BYTES   = 5'd4;
  localparam logic [4:0]  EXTRA_WORD_BYTES = 5'd4;
  localparam logic [4:0]  EXT_HDR_BYTES   = 5'd10;
  localparam logic [2:0]  MSG_TYPE_CONTROL = 3'd3;
  localparam logic [3:0]  SUBTYPE_REQUEST = 4'd1;

  localparam int unsigned FLAG_EXT = 0;
  localparam int unsigned FLAG_ECU = 2;
  localparam int unsigned FLAG_SID = 3;
  localparam int unsigned FLAG_TMS = 4;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SHORT  = 2'd1,
    ERR_BUFFER = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_STD     = 2'd1,
    PH_EXTRA   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic        is_command;
    logic        serial_header_found;
    logic [7:0]  header_type;
    logic [7:0]  message_counter;
    logic [4:0]  header_size;
    logic [15:0] payload_size;
    logic [7:0]  message_info;
    logic [31:0] ecu_id;
    logic [31:0] session_id;
    logic [31:0] timestamp;
    logic [1:0]  error_code;
  } out_item_t;

  typedef struct packed {
    logic     step;
    in_item_t item;
  } step_t;

  function automatic logic [4:0] hdr_size(input logic [7:0] t);
    logic [4:0] s;
    s = STD_HDR_BYTES;
    if (t[FLAG_ECU]) s = s + EXTRA_WORD_BYTES;
    if (t[FLAG_SID]) s = s + EXTRA_WORD_BYTES;
    if (t[FLAG_TMS]) s = s + EXTRA_WORD_BYTES;
    if (t[FLAG_EXT]) s = s + EXT_HDR_BYTES;
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dltd_parser.sv
// Byte-wise message parser: phase state machine, header and field capture.
// Produces one descriptor combinationally on the step that completes it; uses dltd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dltd_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dltd_pkg::step_t    step_in,
  input  wire logic [17:0]        buffer_size,
  output logic                    res_valid,
  output dltd_pkg::out_item_t     res
);

  dltd_pkg::phase_t ph_r, ph_nxt, ph_e;
  logic [4:0]  pos_r, pos_nxt, pos_e;
  logic [31:0] fw_r, fw_nxt, fw_e, fw_shift;
  logic        ser_r, ser_nxt, ser_e;
  logic        halt_r, halt_nxt, halt_e;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  t_r, t_nxt, cnt_r, cnt_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] ecu_r, ecu_nxt, sid_r, sid_nxt, tms_r, tms_nxt;
  logic [7:0]  info_r, info_nxt;

  logic [7:0]  b;
  logic        hdr_done, emit;
  dltd_pkg::err_t err;
  logic [7:0]  hdr_t, hdr_cnt;
  logic [15:0] hdr_len;
  logic [4:0]  hs_r, hs_cur, pos_inc;
  logic [4:0]  bnd_ecu, bnd_sid, bnd_tms;
  logic [16:0] total;

  always_comb begin
    b         = step_in.item.byte_value;
    ph_e      = step_in.item.restart ? dltd_pkg::PH_FIRST : ph_r;
    pos_e     = step_in.item.restart ? 5'd0 : pos_r;
    fw_e      = step_in.item.restart ? 32'd0 : fw_r;
    ser_e     = step_in.item.restart ? 1'b0 : ser_r;
    halt_e    = step_in.item.restart ? 1'b0 : halt_r;
    fw_shift  = {fw_e[23:0], b};
    pos_inc   = 5'(pos_e + 5'd1);
    hs_r      = dltd_pkg::hdr_size(t_r);
    bnd_ecu   = 5'(dltd_pkg::STD_HDR_BYTES +
                   (t_r[dltd_pkg::FLAG_ECU] ? dltd_pkg::EXTRA_WORD_BYTES : 5'd0));
    bnd_sid   = 5'(bnd_ecu +
                   (t_r[dltd_pkg::FLAG_SID] ? dltd_pkg::EXTRA_WORD_BYTES : 5'd0));
    bnd_tms   = 5'(bnd_sid +
                   (t_r[dltd_pkg::FLAG_TMS] ? dltd_pkg::EXTRA_WORD_BYTES : 5'd0));

    ph_nxt   = ph_r;
    pos_nxt  = pos_r;
    fw_nxt   = fw_r;
    ser_nxt  = ser_r;
    halt_nxt = halt_r;
    rem_nxt  = rem_r;
    t_nxt    = t_r;
    cnt_nxt  = cnt_r;
    len_nxt  = len_r;
    ecu_nxt  = ecu_r;
    sid_nxt  = sid_r;
    tms_nxt  = tms_r;
    info_nxt = info_r;
    hdr_done = 1'b0;
    emit     = 1'b0;
    err      = dltd_pkg::ERR_NONE;
    hdr_t    = t_r;
    hdr_cnt  = cnt_r;
    hdr_len  = len_r;

    if (step_in.step) begin
      ph_nxt   = ph_e;
      pos_nxt  = pos_e;
      fw_nxt   = fw_e;
      ser_nxt  = ser_e;
      halt_nxt = halt_e;
      if (!halt_e) begin
        unique case (ph_e)
          dltd_pkg::PH_FIRST: begin
            fw_nxt  = fw_shift;
            pos_nxt = pos_inc;
            if (pos_e == 5'd3) begin
              if (fw_shift == dltd_pkg::SERIAL_WORD) begin
                ser_nxt = 1'b1;
                ph_nxt  = dltd_pkg::PH_STD;
                pos_nxt = 5'd0;
              end else begin
                hdr_done = 1'b1;
                hdr_t    = fw_shift[31:24];
                hdr_cnt  = fw_shift[23:16];
                hdr_len  = fw_shift[15:0];
              end
            end
          end
          dltd_pkg::PH_STD: begin
            pos_nxt = pos_inc;
            case (pos_e[1:0])
              2'd0:    t_nxt = b;
              2'd1:    cnt_nxt = b;
              2'd2:    len_nxt = {b, len_r[7:0]};
              default: begin
                hdr_done = 1'b1;
                hdr_len  = {len_r[15:8], b};
              end
            endcase
          end
          dltd_pkg::PH_EXTRA: begin
            pos_nxt = pos_inc;
            if (pos_e < bnd_ecu) begin
              ecu_nxt = {ecu_r[23:0], b};
            end else if (pos_e < bnd_sid) begin
              sid_nxt = {sid_r[23:0], b};
            end else if (pos_e < bnd_tms) begin
              tms_nxt = {tms_r[23:0], b};
            end else if (pos_e == bnd_tms) begin
              info_nxt = b;
            end
            if (pos_inc == hs_r) begin
              if (len_r == {11'd0, hs_r}) begin
                emit = 1'b1;
              end else begin
                ph_nxt  = dltd_pkg::PH_PAYLOAD;
                pos_nxt = 5'd0;
                rem_nxt = 16'(len_r - {11'd0, hs_r});
              end
            end
          end
          dltd_pkg::PH_PAYLOAD: begin
            rem_nxt = 16'(rem_r - 16'd1);
            if (rem_r == 16'd1) begin
              emit = 1'b1;
            end
          end
          default: begin
            ph_nxt = dltd_pkg::PH_FIRST;
          end
        endcase
      end
    end

    hs_cur = dltd_pkg::hdr_size(hdr_t);
    total  = 17'({1'b0, hdr_len} + (ser_nxt ? 17'd4 : 17'd0));

    if (hdr_done) begin
      t_nxt    = hdr_t;
      cnt_nxt  = hdr_cnt;
      len_nxt  = hdr_len;
      ecu_nxt  = 32'd0;
      sid_nxt  = 32'd0;
      tms_nxt  = 32'd0;
      info_nxt = 8'd0;
      if (hdr_len < {11'd0, hs_cur}) begin
        emit     = 1'b1;
        err      = dltd_pkg::ERR_SHORT;
        halt_nxt = 1'b1;
      end else if ({1'b0, total} > buffer_size) begin
        emit     = 1'b1;
        err      = dltd_pkg::ERR_BUFFER;
        halt_nxt = 1'b1;
      end else if (hs_cur > dltd_pkg::STD_HDR_BYTES) begin
        ph_nxt  = dltd_pkg::PH_EXTRA;
        pos_nxt = dltd_pkg::STD_HDR_BYTES;
      end else if (hdr_len == {11'd0, hs_cur}) begin
        emit = 1'b1;
      end else begin
        ph_nxt  = dltd_pkg::PH_PAYLOAD;
        pos_nxt = 5'd0;
        rem_nxt = 16'(hdr_len - {11'd0, hs_cur});
      end
    end

    if (emit && err == dltd_pkg::ERR_NONE) begin
      ph_nxt  = dltd_pkg::PH_FIRST;
      pos_nxt = 5'd0;
      fw_nxt  = 32'd0;
      ser_nxt = 1'b0;
    end
  end

  always_comb begin
    res_valid = emit;
    res.is_command = (err == dltd_pkg::ERR_NONE) && hdr_t[dltd_pkg::FLAG_EXT] &&
                     (info_nxt[3:1] == dltd_pkg::MSG_TYPE_CONTROL) &&
                     (info_nxt[7:4] == dltd_pkg::SUBTYPE_REQUEST);
    res.serial_header_found = ser_e;
    res.header_type         = hdr_t;
    res.message_counter     = hdr_cnt;
    res.header_size         = hs_cur;
    res.payload_size        = (hdr_len >= {11'd0, hs_cur}) ?
                              16'(hdr_len - {11'd0, hs_cur}) : 16'd0;
    res.message_info        = (err == dltd_pkg::ERR_NONE) ? info_nxt : 8'd0;
    res.ecu_id              = (err == dltd_pkg::ERR_NONE) ? ecu_nxt : 32'd0;
    res.session_id          = (err == dltd_pkg::ERR_NONE) ? sid_nxt : 32'd0;
    res.timestamp           = (err == dltd_pkg::ERR_NONE) ? tms_nxt : 32'd0;
    res.error_code          = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= dltd_pkg::PH_FIRST;
      pos_r  <= 5'd0;
      fw_r   <= 32'd0;
      ser_r  <= 1'b0;
      halt_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      pos_r  <= pos_nxt;
      fw_r   <= fw_nxt;
      ser_r  <= ser_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    t_r    <= t_nxt;
    cnt_r  <= cnt_nxt;
    len_r  <= len_nxt;
    ecu_r  <= ecu_nxt;
    sid_r  <= sid_nxt;
    tms_r  <= tms_nxt;
    info_r <= info_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/dltd_out_stage.sv
// Result register of the deframer: holds one descriptor until it is taken.
// Uses the descriptor type from dltd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dltd_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire dltd_pkg::out_item_t res,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output dltd_pkg::out_item_t      out_data
);

  logic                valid_r, valid_nxt;
  dltd_pkg::out_item_t data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = res;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: rtl/log_message_deframer_top.sv
// Top level of the log message deframer: input register, buffer size register,
// parser and result register. Depends on dltd_pkg, dltd_parser and dltd_out_stage.
// A byte in the input register is parsed as it advances; its descriptor, if any, goes to
// the result register at that step. Throughput: one byte per cycle while the result
// register is not held, one parser step per byte. Synchronous active-low reset clears the
// parser, the valid flags and sets the buffer size to 65536; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module log_message_deframer_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dltd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dltd_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [17:0]         cfg_data
);

  logic               s1_valid_r, s1_valid_nxt;
  dltd_pkg::in_item_t s1_item_r, s1_item_nxt;
  logic [17:0]        buf_size_r, buf_size_nxt;
  logic               advance, in_take;
  dltd_pkg::step_t    step;
  logic               res_valid;
  dltd_pkg::out_item_t res;

  assign advance   = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = in_take || (s1_valid_r && !advance);
    s1_item_nxt  = in_take ? in_data : s1_item_r;
    buf_size_nxt = (cfg_valid && cfg_ready) ? cfg_data : buf_size_r;
    step.step    = advance;
    step.item    = s1_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      buf_size_r <= dltd_pkg::BUF_SIZE_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      buf_size_r <= buf_size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  dltd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_in     (step),
    .buffer_size (buf_size_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  dltd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !(out_valid && out_stall))
    else $error("parser stepped while the result register was held");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != dltd_pkg::ERR_NONE) |->
      (!out_data.is_command && out_data.ecu_id == 32'd0 && out_data.message_info == 8'd0))
    else $error("error descriptor carries optional header fields");

  a_header_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.header_size == dltd_pkg::hdr_size(out_data.header_type)))
    else $error("header size does not match the type byte");

endmodule

`default_nettype wire
